@@ sv/ncfm_pkg.sv @@
// Package for the nibble class first-match scanner: sizes, result and
// merge types, saturating offset helpers. No dependencies.
`default_nettype none
package ncfm_pkg;

  localparam int LANES       = 16;
  localparam int OFFSET_BITS = 32;

  // Scan width: at most 16 bytes arrive per chunk.
  localparam int LIMIT     = (LANES < 16) ? LANES : 16;
  localparam int LANE_IDX_W = (LIMIT > 1) ? $clog2(LIMIT) : 1;
  localparam int CNT_W     = 5;
  localparam int OUT_W     = 32;
  localparam int EXT_W     = (OFFSET_BITS > OUT_W) ? OFFSET_BITS : OUT_W;
  localparam int TAB_W     = 128;
  localparam int IDX_W     = 8;

  typedef enum logic [IDX_W-1:0] {
    REG_LO_TABLE_LOW  = 8'd0,
    REG_LO_TABLE_HIGH = 8'd1,
    REG_HI_TABLE_LOW  = 8'd2,
    REG_HI_TABLE_HIGH = 8'd3
  } cfg_reg_t;

  typedef logic [OFFSET_BITS-1:0] offset_t;

  typedef struct packed {
    logic                  hit;
    logic [LANE_IDX_W-1:0] idx;
  } scan_hit_t;

  typedef struct packed {
    logic             found;
    logic [OUT_W-1:0] offset;
    logic             done;
  } result_t;

  function automatic offset_t sat_add(input offset_t a, input logic [CNT_W-1:0] b);
    logic [OFFSET_BITS:0] sum;
    sum = {1'b0, a} + (OFFSET_BITS + 1)'(b);
    return sum[OFFSET_BITS] ? {OFFSET_BITS{1'b1}} : sum[OFFSET_BITS-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] out_sat(input offset_t a);
    logic [EXT_W-1:0] v;
    v = EXT_W'(a);
    return (v > EXT_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : v[OUT_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ sv/nibble_class_first_match_scan.sv @@
// Top level of the nibble class first-match scanner: lanes, merge, buffer
// state and a two-entry result queue. Depends on ncfm_pkg, ncfm_lane, ncfm_merge.
//
// Usage:
//  - cfg channel writes the four 64-bit table words (index 0..3: lo low,
//    lo high, hi low, hi high). Other indexes are ignored. cfg_ready is always
//    high; write tables only while no chunk is in flight.
//  - in channel carries one chunk per transaction: up to 16 bytes plus the
//    count of valid leading bytes; in_tlast closes the buffer.
//  - out channel returns one result per chunk: offset of the first class byte
//    (out_tuser = 1) or the bytes consumed so far (out_tuser = 0); out_tlast
//    marks the result of the closing chunk.
// Throughput: one chunk per cycle while in_tready is high. All lanes classify
// in parallel, and the per-buffer state (bytes seen, first match) updates in
// the accept cycle. Results are registered in the queue and leave from its head.
// Stalls: results wait in a two-entry queue; in_tready is registered and drops
// only when the queue is full, so a held result does not block the next chunk.
// Reset (rst_n low, synchronous): tables cleared, buffer state cleared, queue
// emptied, in_tready low for the reset cycles.
`default_nettype none
module nibble_class_first_match_scan (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // cfg write channel
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [ncfm_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [63:0]  cfg_data,
  // input stream
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [63:0] bytes_first_half, [127:64] bytes_second_half,
  // [132:128] valid_count, [135:133] zero
  input  wire logic [135:0] in_tdata,
  input  wire logic         in_tlast,      // last_chunk
  // result stream
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [31:0]       out_tdata,     // [31:0] match_offset
  output logic              out_tuser,     // [0] match_found
  output logic              out_tlast      // scan_done
);
  import ncfm_pkg::*;

  // ---------------- configuration tables ----------------
  logic [63:0] lo_low_r, lo_high_r, hi_low_r, hi_high_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_low_r  <= '0;
      lo_high_r <= '0;
      hi_low_r  <= '0;
      hi_high_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LO_TABLE_LOW:  lo_low_r  <= cfg_data;
        REG_LO_TABLE_HIGH: lo_high_r <= cfg_data;
        REG_HI_TABLE_LOW:  hi_low_r  <= cfg_data;
        REG_HI_TABLE_HIGH: hi_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [TAB_W-1:0] lo_tab, hi_tab;
  assign lo_tab = {lo_high_r, lo_low_r};
  assign hi_tab = {hi_high_r, hi_low_r};

  // ---------------- input decode ----------------
  logic             in_xfer;
  logic [127:0]     chunk;
  logic [CNT_W-1:0] raw_cnt;
  logic [CNT_W-1:0] cnt;

  assign in_xfer = in_tvalid && in_tready;
  assign chunk   = in_tdata[127:0];
  assign raw_cnt = in_tdata[132:128];
  // counts above the lane count are clamped
  assign cnt     = (raw_cnt > CNT_W'(LIMIT)) ? CNT_W'(LIMIT) : raw_cnt;

  // ---------------- buffer state ----------------
  offset_t bytes_seen_r, bytes_seen_nxt;
  offset_t found_pos_r, found_pos_nxt;
  logic    found_r, found_nxt;

  // ---------------- lanes ----------------
  logic [LIMIT-1:0] lane_match;
  scan_hit_t        hit;

  for (genvar k = 0; k < LIMIT; k++) begin : g_lane
    ncfm_lane u_lane (
      .byte_in (chunk[8*k +: 8]),
      // lanes idle once the buffer already has its first match
      .en      ((CNT_W'(k) < cnt) && !found_r),
      .lo_tab  (lo_tab),
      .hi_tab  (hi_tab),
      .match   (lane_match[k])
    );
  end

  ncfm_merge u_merge (
    .lane_match (lane_match),
    .hit        (hit)
  );

  // State after this chunk, before a closing chunk clears it.
  offset_t    seen_upd, pos_upd;
  logic       found_upd;
  result_t    res;

  always_comb begin
    seen_upd  = sat_add(bytes_seen_r, cnt);
    found_upd = found_r || hit.hit;
    pos_upd   = found_r ? found_pos_r : sat_add(bytes_seen_r, CNT_W'(hit.idx));
    if (!found_upd) begin
      pos_upd = found_pos_r;
    end
    res.found  = found_upd;
    res.offset = out_sat(found_upd ? pos_upd : seen_upd);
    res.done   = in_tlast;
  end

  always_comb begin
    bytes_seen_nxt = bytes_seen_r;
    found_nxt      = found_r;
    found_pos_nxt  = found_pos_r;
    if (in_xfer) begin
      if (in_tlast) begin
        bytes_seen_nxt = '0;
        found_nxt      = 1'b0;
        found_pos_nxt  = '0;
      end else begin
        bytes_seen_nxt = seen_upd;
        found_nxt      = found_upd;
        found_pos_nxt  = pos_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= '0;
      found_r      <= 1'b0;
      found_pos_r  <= '0;
    end else begin
      bytes_seen_r <= bytes_seen_nxt;
      found_r      <= found_nxt;
      found_pos_r  <= found_pos_nxt;
    end
  end

  // ---------------- result queue (two entries) ----------------
  result_t    q_mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] q_cnt_r, q_cnt_nxt;
  logic       in_tready_r, in_tready_nxt;
  logic       out_xfer;

  assign out_xfer = out_tvalid && out_tready;

  always_comb begin
    wr_ptr_nxt    = wr_ptr_r ^ in_xfer;
    rd_ptr_nxt    = rd_ptr_r ^ out_xfer;
    q_cnt_nxt     = q_cnt_r + 2'(in_xfer) - 2'(out_xfer);
    in_tready_nxt = (q_cnt_nxt < 2'd2);
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      q_mem[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= 1'b0;
      rd_ptr_r    <= 1'b0;
      q_cnt_r     <= '0;
      in_tready_r <= 1'b0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      q_cnt_r     <= q_cnt_nxt;
      in_tready_r <= in_tready_nxt;
    end
  end

  result_t head;
  assign head       = q_mem[rd_ptr_r];
  assign in_tready  = in_tready_r;
  assign out_tvalid = (q_cnt_r != 2'd0);
  assign out_tdata  = head.offset;
  assign out_tuser  = head.found;
  assign out_tlast  = head.done;

  // ---------------- assertions ----------------
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= 2'd2)
    else $error("result queue overflow");

  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt_r == 2'd2) && !out_xfer |-> !in_xfer)
    else $error("chunk accepted with full queue");

  a_pos_le_seen: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> (found_pos_r <= bytes_seen_r))
    else $error("first match beyond bytes seen");

  a_hold_match: assert property (@(posedge clk) disable iff (!rst_n)
    found_r && in_xfer && !in_tlast |=> found_r && $stable(found_pos_r))
    else $error("first match offset changed within buffer");

  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tlast |=> !found_r && (bytes_seen_r == '0))
    else $error("closing chunk did not clear state");

endmodule
`default_nettype wire

@@ sv/ncfm_lane.sv @@
// One scan lane: classifies a single byte against the nibble tables.
// Depends on ncfm_pkg.
`default_nettype none
module ncfm_lane (
  input  wire logic [7:0]             byte_in,
  input  wire logic                   en,
  input  wire logic [ncfm_pkg::TAB_W-1:0] lo_tab,
  input  wire logic [ncfm_pkg::TAB_W-1:0] hi_tab,
  output logic                        match
);
  import ncfm_pkg::*;

  logic [7:0] lo_ent;
  logic [7:0] hi_ent;

  assign lo_ent = lo_tab[{byte_in[3:0], 3'b000} +: 8];
  assign hi_ent = hi_tab[{byte_in[7:4], 3'b000} +: 8];
  // any common bit, bit 7 included
  assign match  = en && ((lo_ent & hi_ent) != 8'h00);

endmodule
`default_nettype wire

@@ sv/ncfm_merge.sv @@
// Merge stage: picks the lowest lane that reported a class byte.
// Depends on ncfm_pkg.
`default_nettype none
module ncfm_merge (
  input  wire logic [ncfm_pkg::LIMIT-1:0] lane_match,
  output ncfm_pkg::scan_hit_t             hit
);
  import ncfm_pkg::*;

  always_comb begin
    hit = '0;
    for (int k = LIMIT - 1; k >= 0; k--) begin
      if (lane_match[k]) begin
        hit.hit = 1'b1;
        hit.idx = LANE_IDX_W'(k);
      end
    end
  end

endmodule
`default_nettype wire
